@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ETT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ETT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ett_pkg.sv @@
// ---------------------------------------------------------------------------
// ett_pkg
// types and codes of the event timer table
// ---------------------------------------------------------------------------
package ett_pkg;

  // operation modes
  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_UPDATE = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [7:0] TASK_COUNT_RST = 8'd8;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  task_req;
    logic [3:0]  event_req;
    logic [31:0] timeout;
    logic [7:0]  tick_delta;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] remaining;
    logic [7:0]  expired_task;
    logic [3:0]  expired_event;
    logic        last;
  } out_word_t;

  // one timer slot as held in the memory
  typedef struct packed {
    logic [31:0] remaining;
    logic [7:0]  task_id;
    logic [3:0]  event_num;
  } slot_t;

endpackage

@@ rtl/event_timer_table.sv @@
// ---------------------------------------------------------------------------
// event_timer_table
// table of one-shot countdown timers keyed by task and event number
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  in        input      in_valid_i / in_stall_o   ett_pkg::in_word_t
//  out       output     out_valid_o / out_stall_i ett_pkg::out_word_t
//  cfg       input      cfg_we_i                  task_count, 8 bit
//
//  invalid operations and ticks with zero delta skip the scan; every other
//  operation scans the slot memory once, one slot a cycle through its single
//  read port while the output does not stall; the input is stalled until the
//  closing word is loaded, so the next word is taken only after that
//  a stalled output holds the scan at the slot whose expiry waits
//  reset clears the slot active bits and sets the task count to 8, no clearing pass
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module event_timer_table #(
  parameter int SLOTS  = 16,
  parameter int EVENTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ett_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ett_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]         state_q, state_d;
  ett_pkg::in_word_t  req_q, req_d;
  logic               invalid_q, invalid_d;
  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic               rvalid_q, rvalid_d;
  logic [IdxW-1:0]    ev_idx_q, ev_idx_d;
  logic               match_q, match_d;
  logic [IdxW-1:0]    match_idx_q, match_idx_d;
  logic [31:0]        match_rem_q, match_rem_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [7:0]         task_count_q;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  ett_pkg::slot_t     mem_wdata;
  logic               mem_re;
  ett_pkg::slot_t     rd;

  logic               out_load;
  ett_pkg::out_word_t out_word;
  logic               out_free;

  logic               in_acc;
  logic               is_tick;
  logic               ev_active;
  logic               hit;
  logic [31:0]        sub_rem;
  logic               need_emit;
  logic               eval_go;
  logic               stage_free;
  logic               key_ok;

  ett_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (rd)
  );

  ett_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .word_i  (out_word),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // key check against the live register
  assign key_ok = (in_word_i.task_req < task_count_q) &&
                  (32'(in_word_i.event_req) < 32'(EVENTS));

  // evaluation of the slot held in the read register
  assign is_tick    = (req_q.mode == ett_pkg::MODE_TICK);
  assign ev_active  = active_q[ev_idx_q];
  assign hit        = ev_active && (rd.task_id == req_q.task_req) &&
                      (rd.event_num == req_q.event_req);
  assign sub_rem    = (rd.remaining >= 32'(req_q.tick_delta)) ?
                      (rd.remaining - 32'(req_q.tick_delta)) : 32'd0;
  assign need_emit  = rvalid_q && is_tick && ev_active && (sub_rem == 32'd0);
  assign eval_go    = rvalid_q && (!need_emit || out_free);
  assign stage_free = !rvalid_q || eval_go;
  assign mem_re     = (state_q == ST_SCAN) && (rd_idx_q < CntW'(SLOTS)) && stage_free;

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    invalid_d   = invalid_q;
    rd_idx_d    = rd_idx_q;
    rvalid_d    = rvalid_q;
    ev_idx_d    = ev_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_rem_d = match_rem_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    active_d    = active_q;
    mem_we      = 1'b0;
    mem_waddr   = ev_idx_q;
    mem_wdata   = '{remaining: sub_rem, task_id: rd.task_id, event_num: rd.event_num};
    out_load    = 1'b0;
    out_word    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d     = in_word_i;
          invalid_d = (in_word_i.mode > ett_pkg::MODE_TICK) ||
                      ((in_word_i.mode != ett_pkg::MODE_TICK) &&
                       (!key_ok ||
                        (((in_word_i.mode == ett_pkg::MODE_CREATE) ||
                          (in_word_i.mode == ett_pkg::MODE_UPDATE)) &&
                         (in_word_i.timeout == 32'd0))));
          rd_idx_d  = '0;
          rvalid_d  = 1'b0;
          match_d   = 1'b0;
          free_d    = 1'b0;
          if (invalid_d || ((in_word_i.mode == ett_pkg::MODE_TICK) &&
                            (in_word_i.tick_delta == 8'd0))) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mem_re) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (stage_free) begin
          rvalid_d = mem_re;
          ev_idx_d = rd_idx_q[IdxW-1:0];
        end
        if (eval_go) begin
          if (is_tick) begin
            // countdown with saturation, expiry frees the slot
            if (ev_active) begin
              mem_we = 1'b1;
              if (sub_rem == 32'd0) begin
                active_d[ev_idx_q]     = 1'b0;
                out_load               = 1'b1;
                out_word.kind          = ett_pkg::KIND_EXPIRY;
                out_word.status        = ett_pkg::ST_OK;
                out_word.expired_task  = rd.task_id;
                out_word.expired_event = rd.event_num;
              end
            end
          end else begin
            // first match and lowest free slot
            if (hit && !match_q) begin
              match_d     = 1'b1;
              match_idx_d = ev_idx_q;
              match_rem_d = rd.remaining;
            end
            if (!ev_active && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = ev_idx_q;
            end
          end
        end
        if ((rd_idx_q == CntW'(SLOTS)) && !rvalid_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        mem_wdata = '{remaining: req_q.timeout, task_id: req_q.task_req,
                      event_num: req_q.event_req};
        out_word.kind   = is_tick ? ett_pkg::KIND_DONE : ett_pkg::KIND_REPLY;
        out_word.status = ett_pkg::ST_OK;
        out_word.last   = 1'b1;
        if (invalid_q) begin
          out_word.status = ett_pkg::ST_INVALID;
        end else begin
          unique case (req_q.mode)
            ett_pkg::MODE_CREATE: begin
              if (match_q) begin
                mem_we    = out_free;
                mem_waddr = match_idx_q;
              end else if (free_q) begin
                mem_we    = out_free;
                mem_waddr = free_idx_q;
                if (out_free) begin
                  active_d[free_idx_q] = 1'b1;
                end
              end else begin
                out_word.status = ett_pkg::ST_FULL;
              end
            end
            ett_pkg::MODE_UPDATE: begin
              if (match_q) begin
                mem_we    = out_free;
                mem_waddr = match_idx_q;
              end else begin
                out_word.status = ett_pkg::ST_NOTFOUND;
              end
            end
            ett_pkg::MODE_DELETE: begin
              if (match_q) begin
                if (out_free) begin
                  active_d[match_idx_q] = 1'b0;
                end
              end else begin
                out_word.status = ett_pkg::ST_NOTFOUND;
              end
            end
            ett_pkg::MODE_QUERY: begin
              out_word.remaining = match_q ? match_rem_q : 32'd0;
            end
            default: begin
              // tick: done word only
            end
          endcase
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
      active_q <= '0;
      rd_idx_q <= '0;
      match_q  <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      active_q <= active_d;
      rd_idx_q <= rd_idx_d;
      match_q  <= match_d;
      free_q   <= free_d;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    invalid_q   <= invalid_d;
    ev_idx_q    <= ev_idx_d;
    match_idx_q <= match_idx_d;
    match_rem_q <= match_rem_d;
    free_idx_q  <= free_idx_d;
  end

  // task count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= ett_pkg::TASK_COUNT_RST;
    end else if (cfg_we_i) begin
      task_count_q <= cfg_wdata_i;
    end
  end

  // assertions
  `ETT_ASSERT(a_no_rw_clash, clk_i, rst_ni, (mem_we && mem_re) |-> (mem_waddr != rd_idx_q[IdxW-1:0]), "write back collides with scan read")
  `ETT_ASSERT(a_rvalid_in_scan, clk_i, rst_ni, rvalid_q |-> (state_q == ST_SCAN), "slot read pending outside scan")
  `ETT_ASSERT(a_last_at_finish, clk_i, rst_ni, (out_load && out_word.last) |-> (state_q == ST_FINISH), "closing word issued mid scan")
  `ETT_ASSERT(a_load_when_free, clk_i, rst_ni, out_load |-> out_free, "output word overwritten")
  `ETT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == ST_IDLE), "sequencer not idle in reset")

endmodule

@@ rtl/ett_slot_mem.sv @@
// ---------------------------------------------------------------------------
// ett_slot_mem
// timer slot memory, one write and one registered read port
// ---------------------------------------------------------------------------
module ett_slot_mem #(
  parameter int SLOTS = 16,
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  ett_pkg::slot_t   wdata_i,
  input  logic             re_i,
  input  logic [IdxW-1:0]  raddr_i,
  output ett_pkg::slot_t   rdata_o
);

  ett_pkg::slot_t mem_q [SLOTS];
  ett_pkg::slot_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ett_out_reg.sv @@
// ---------------------------------------------------------------------------
// ett_out_reg
// result holding register between the sequencer and the output channel
// ---------------------------------------------------------------------------
module ett_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ett_pkg::out_word_t  word_i,
  input  logic                stall_i,
  output logic                free_o,
  output logic                valid_o,
  output ett_pkg::out_word_t  word_o
);

  logic               valid_q;
  ett_pkg::out_word_t word_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ dv/event_timer_table_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// event_timer_table_checker
// watches both channels and the register port of the timer table, keeps its
// own copy of the slot table and the task count, works out the words that
// each accepted request must produce and compares them, in order, with the
// words the block delivers
// ---------------------------------------------------------------------------
module event_timer_table_checker #(
  parameter int SLOTS  = 16,
  parameter int EVENTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ett_pkg::in_word_t   in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ett_pkg::out_word_t  out_word_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output int                  mismatch_count_o,
  output int                  results_due_o
);

  // predicted table contents
  logic [31:0] slot_left  [SLOTS];
  logic [7:0]  slot_owner [SLOTS];
  logic [3:0]  slot_evt   [SLOTS];
  logic [7:0]  task_limit;

  ett_pkg::out_word_t due_words [$];

  function automatic void queue_word(logic [1:0] kind, logic [1:0] status,
                                     logic [31:0] left, logic [7:0] owner,
                                     logic [3:0] evt, logic last);
    ett_pkg::out_word_t w;
    w = {kind, status, left, owner, evt, last};
    due_words.push_back(w);
  endfunction

  // one request against the predicted table
  task automatic advance_table(input ett_pkg::in_word_t req);
    int          i;
    int          hit;
    logic        key_ok;
    logic [31:0] delta;
    hit    = SLOTS;
    key_ok = (req.task_req < task_limit) && (32'(req.event_req) < 32'(EVENTS));
    delta  = {24'd0, req.tick_delta};
    if (req.mode == ett_pkg::MODE_TICK) begin
      // saturating countdown, expiries in slot order, then done
      if (delta != 0) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_left[i] != 0) begin
            slot_left[i] = (slot_left[i] >= delta) ? slot_left[i] - delta : 32'd0;
            if (slot_left[i] == 0)
              queue_word(ett_pkg::KIND_EXPIRY, ett_pkg::ST_OK, '0, slot_owner[i],
                         slot_evt[i], 1'b0);
          end
        end
      end
      queue_word(ett_pkg::KIND_DONE, ett_pkg::ST_OK, '0, '0, '0, 1'b1);
    end else if (req.mode > ett_pkg::MODE_TICK || !key_ok ||
                 ((req.mode == ett_pkg::MODE_CREATE || req.mode == ett_pkg::MODE_UPDATE) &&
                  req.timeout == 0)) begin
      queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_INVALID, '0, '0, '0, 1'b1);
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (hit == SLOTS && slot_left[i] != 0 && slot_owner[i] == req.task_req &&
            slot_evt[i] == req.event_req)
          hit = i;
      end
      case (req.mode)
        ett_pkg::MODE_CREATE: begin
          if (hit == SLOTS) begin
            // claim the lowest free slot
            for (i = 0; i < SLOTS; i++) begin
              if (hit == SLOTS && slot_left[i] == 0)
                hit = i;
            end
          end
          if (hit == SLOTS) begin
            queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_FULL, '0, '0, '0, 1'b1);
          end else begin
            slot_left[hit]  = req.timeout;
            slot_owner[hit] = req.task_req;
            slot_evt[hit]   = req.event_req;
            queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_OK, '0, '0, '0, 1'b1);
          end
        end
        ett_pkg::MODE_UPDATE, ett_pkg::MODE_DELETE: begin
          if (hit == SLOTS) begin
            queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_NOTFOUND, '0, '0, '0, 1'b1);
          end else begin
            slot_left[hit] = (req.mode == ett_pkg::MODE_UPDATE) ? req.timeout : 32'd0;
            queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_OK, '0, '0, '0, 1'b1);
          end
        end
        default: begin
          queue_word(ett_pkg::KIND_REPLY, ett_pkg::ST_OK,
                     (hit == SLOTS) ? 32'd0 : slot_left[hit], '0, '0, 1'b1);
        end
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  // sample every handshake at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    ett_pkg::out_word_t want;
    int                 i;
    if (!rst_ni) begin
      for (i = 0; i < SLOTS; i++) begin
        slot_left[i]  = '0;
        slot_owner[i] = '0;
        slot_evt[i]   = '0;
      end
      task_limit = ett_pkg::TASK_COUNT_RST;
      due_words.delete();
      mismatch_count_o = 0;
      results_due_o    = 0;
    end else begin
      if (cfg_we_i)
        task_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        advance_table(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $error("word with nothing due: %p", out_word_i);
          mismatch_count_o++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_word_i.kind));
          check_field("status", 32'(want.status), 32'(out_word_i.status));
          check_field("remaining", want.remaining, out_word_i.remaining);
          check_field("expired_task", 32'(want.expired_task),
                      32'(out_word_i.expired_task));
          check_field("expired_event", 32'(want.expired_event),
                      32'(out_word_i.expired_event));
          check_field("last", 32'(want.last), 32'(out_word_i.last));
        end
      end
      results_due_o = due_words.size();
    end
  end

endmodule

@@ dv/event_timer_table_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// event_timer_table_tb
// drives requests into the timer table and drains its words with random
// gaps and stalls, through several task counts; a directed opening covers
// bad keys, zero timeouts, unknown modes, rearm, delete, query and zero
// delta ticks, then random requests on a small key pool fill and drain the
// table. the checker beside the block predicts and compares every word
// ---------------------------------------------------------------------------
module event_timer_table_tb;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  // modes the block must refuse
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ett_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ett_pkg::out_word_t out_word;
  logic               cfg_we    = 1'b0;
  logic [7:0]         cfg_wdata = '0;

  int         mismatches;
  int         words_due;
  int         idle_cycles = 0;
  int         cur_tasks   = int'(ett_pkg::TASK_COUNT_RST);
  bit         calm        = 1'b0;
  bit         hold_req    = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  event_timer_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  event_timer_table_checker timer_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .results_due_o    (words_due)
  );

  function automatic ett_pkg::in_word_t request(logic [2:0] mode, logic [7:0] tsk,
                                                logic [3:0] evt, logic [31:0] tmo,
                                                logic [7:0] delta);
    ett_pkg::in_word_t w;
    w = {mode, tsk, evt, tmo, delta};
    return w;
  endfunction

  // mostly keys from a small pool so timers collide, rearm and fill the table
  function automatic ett_pkg::in_word_t random_request();
    int                pick;
    int                pool;
    ett_pkg::in_word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 35)      w.mode = ett_pkg::MODE_CREATE;
    else if (pick < 47) w.mode = ett_pkg::MODE_UPDATE;
    else if (pick < 57) w.mode = ett_pkg::MODE_DELETE;
    else if (pick < 72) w.mode = ett_pkg::MODE_QUERY;
    else if (pick < 95) w.mode = ett_pkg::MODE_TICK;
    else                w.mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    pool = (cur_tasks > 6) ? 5 : cur_tasks - 1;
    w.task_req  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, pool));
    w.event_req = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 3));
    pick = $urandom_range(0, 19);
    if (pick == 0)      w.timeout = '0;
    else if (pick == 1) w.timeout = '1;
    else if (pick == 2) w.timeout = $urandom();
    else                w.timeout = $urandom_range(1, 400);
    pick = $urandom_range(0, 9);
    if (pick == 0)      w.tick_delta = '0;
    else if (pick < 3)  w.tick_delta = 8'($urandom_range(1, 255));
    else                w.tick_delta = 8'($urandom_range(1, 60));
    return w;
  endfunction

  // offer one word and return at the edge that takes it
  task automatic send_request(input ett_pkg::in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // stop offering, let every due word arrive, then let the scan finish
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [7:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_tasks = int'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_request(random_request());
  endtask

  // output side: random stall per word, one long hold-off on request
  initial begin : drain_words
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("event_timer_table_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset task count
    send_request(request(ett_pkg::MODE_QUERY,  8'd0,   4'd0,  32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_UPDATE, 8'd0,   4'd0,  32'd5,  8'd0));
    send_request(request(ett_pkg::MODE_DELETE, 8'd0,   4'd0,  32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_CREATE, 8'd0,   4'd0,  32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_UPDATE, 8'd1,   4'd2,  32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_CREATE, 8'd8,   4'd0,  32'd10, 8'd0));
    send_request(request(ett_pkg::MODE_QUERY,  8'd255, 4'd15, 32'd0,  8'd0));
    send_request(request(MODE_RSVD5,           8'd0,   4'd0,  32'd1,  8'd1));
    send_request(request(MODE_RSVD6,           8'd1,   4'd1,  32'd1,  8'd0));
    send_request(request(MODE_RSVD7,           8'd2,   4'd3,  32'd7,  8'd255));
    send_request(request(ett_pkg::MODE_CREATE, 8'd7,   4'd15, '1,     8'd255));
    send_request(request(ett_pkg::MODE_QUERY,  8'd7,   4'd15, '1,     8'd255));
    send_request(request(ett_pkg::MODE_CREATE, 8'd0,   4'd0,  32'd1,  8'd0));
    // rearm of an active key
    send_request(request(ett_pkg::MODE_CREATE, 8'd0,   4'd0,  32'd3,  8'd0));
    send_request(request(ett_pkg::MODE_CREATE, 8'd3,   4'd9,  32'd255, 8'd0));
    // zero delta with key and timeout that the tick ignores
    send_request(request(ett_pkg::MODE_TICK,   8'd255, 4'd15, '1,     8'd0));
    send_request(request(ett_pkg::MODE_TICK,   8'd0,   4'd0,  32'd0,  8'd3));
    send_request(request(ett_pkg::MODE_UPDATE, 8'd3,   4'd9,  32'd2,  8'd0));
    send_request(request(ett_pkg::MODE_QUERY,  8'd3,   4'd9,  32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_DELETE, 8'd7,   4'd15, 32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_QUERY,  8'd7,   4'd15, 32'd0,  8'd0));
    send_request(request(ett_pkg::MODE_TICK,   8'd9,   4'd1,  32'd4,  8'd255));
    send_request(request(ett_pkg::MODE_CREATE, 8'd7,   4'd15, 32'd300, 8'd17));
    send_request(request(ett_pkg::MODE_TICK,   8'd0,   4'd0,  32'd0,  8'd255));
    send_request(request(ett_pkg::MODE_QUERY,  8'd7,   4'd15, 32'd0,  8'd0));

    // widest task range, with one long hold-off on the output side
    set_task_count(8'd255);
    hold_req = 1'b1;
    send_random(100);

    // narrowest task range
    set_task_count(8'd1);
    send_random(60);

    set_task_count(8'($urandom_range(2, 254)));
    send_random(100);

    // back to the reset value, no idling on either side
    set_task_count(ett_pkg::TASK_COUNT_RST);
    calm = 1'b1;
    send_random(80);
    calm = 1'b0;

    set_task_count(8'd16);
    send_random(90);

    wait_quiet();
    @(negedge clk);
    if (mismatches == 0)
      $display("event_timer_table_tb: PASS");
    else
      $display("event_timer_table_tb: FAIL");
    $finish;
  end

endmodule
